// ----- design/nwc_pkg.sv -----
// Shared constants, codes and control types for the normalized window correlation core.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package nwc_pkg;

  localparam int MAX_SEARCH_X_DEF = 32;
  localparam int MAX_SEARCH_Y_DEF = 32;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 7;
  localparam int SHIFT_W = 7;
  localparam int CFG_W   = 6;
  localparam int CORR_W  = 15;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd16;

  // item command codes
  localparam logic [CMD_W-1:0] CMD_WR_FIRST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_SECOND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE   = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_SEARCH_X = 1'b0;
  localparam logic REG_SEARCH_Y = 1'b1;

  // arithmetic widths
  localparam int ACC_W  = 64;   // wrapping sums
  localparam int SQ_W   = 128;  // aa*bb, mag*mag
  localparam int PROD_W = 160;  // serial multiplier accumulator
  localparam int MY_W   = 64;   // serial multiplier operand
  localparam int RBITS  = 15;

  localparam logic [RBITS-1:0] FULL_SCALE    = 15'd25600;
  localparam logic [MY_W-1:0]  FULL_SCALE_SQ = 64'd655360000;
  localparam logic [3:0]       RBIT_TOP      = 4'd14;

  typedef enum logic [2:0] {
    MOP_P = 3'd0,   // aa * bb
    MOP_M = 3'd1,   // mag * mag
    MOP_R = 3'd2,   // mag^2 * full scale^2
    MOP_S = 3'd3,   // cand * cand
    MOP_T = 3'd4    // cand^2 * aa*bb
  } mop_t;

  typedef struct packed {
    logic wr_first;
    logic wr_second;
    logic sum_start;
    logic mul_start;
    mop_t mop;
    logic res_load;
    logic res_zero;
  } nwc_cmd_t;

  typedef struct packed {
    logic sum_busy;
    logic mul_busy;
    logic zero_den;
    logic last_bit;
  } nwc_sts_t;

endpackage

// ----- design/nwc_if.sv -----
// Item channel interfaces (input item, result item) for the correlation core.
// Depends on nwc_pkg.
`timescale 1ns / 1ps

interface nwc_in_if #(parameter int SAMPLE_BITS = nwc_pkg::SAMPLE_BITS_DEF);
  import nwc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [POS_W-1:0]          row;
  logic [POS_W-1:0]          column;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SHIFT_W-1:0] shift_x;
  logic signed [SHIFT_W-1:0] shift_y;
  modport source (output valid, command, row, column, sample, shift_x, shift_y,
                  input ready);
  modport sink (input valid, command, row, column, sample, shift_x, shift_y,
                output ready);
endinterface

interface nwc_out_if;
  import nwc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CORR_W-1:0] correlation;
  logic              zero_denominator;
  modport source (output valid, correlation, zero_denominator, input ready);
  modport sink (input valid, correlation, zero_denominator, output ready);
endinterface

// ----- design/nwc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nwc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/nwc_ctrl.sv -----
// Sequencer for the correlation core: handshakes, sum phase, multiply/search steps.
// Depends on nwc_pkg.
`timescale 1ns / 1ps

module nwc_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [nwc_pkg::CMD_W-1:0] in_command,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output nwc_pkg::nwc_cmd_t        cmd,
  input  nwc_pkg::nwc_sts_t        sts
);
  import nwc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SUM  = 7'b0000010,
    S_MP   = 7'b0000100,
    S_MM   = 7'b0001000,
    S_MR   = 7'b0010000,
    S_MS   = 7'b0100000,
    S_MT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   in_acc;

  // a compute item waits until the previous result has left
  assign in_ready = (state == S_IDLE) && ((in_command != CMD_COMPUTE) || !out_valid);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    cmd.wr_first  = in_acc && (in_command == CMD_WR_FIRST);
    cmd.wr_second = in_acc && (in_command == CMD_WR_SECOND);
    case (state)
      S_IDLE: begin
        if (in_acc && (in_command == CMD_COMPUTE)) begin
          cmd.sum_start = 1'b1;
          state_next    = S_SUM;
        end
      end
      S_SUM: begin
        if (!sts.sum_busy) begin
          if (sts.zero_den) begin
            cmd.res_load = 1'b1;
            cmd.res_zero = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.mop       = MOP_P;
            state_next    = S_MP;
          end
        end
      end
      S_MP: begin
        if (!sts.mul_busy) begin
          cmd.mul_start = 1'b1;
          cmd.mop       = MOP_M;
          state_next    = S_MM;
        end
      end
      S_MM: begin
        if (!sts.mul_busy) begin
          cmd.mul_start = 1'b1;
          cmd.mop       = MOP_R;
          state_next    = S_MR;
        end
      end
      S_MR: begin
        if (!sts.mul_busy) begin
          cmd.mul_start = 1'b1;
          cmd.mop       = MOP_S;
          state_next    = S_MS;
        end
      end
      S_MS: begin
        if (!sts.mul_busy) begin
          cmd.mul_start = 1'b1;
          cmd.mop       = MOP_T;
          state_next    = S_MT;
        end
      end
      S_MT: begin
        if (!sts.mul_busy) begin
          if (sts.last_bit) begin
            cmd.res_load = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.mop       = MOP_S;
            state_next    = S_MS;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/nwc_dp.sv -----
// Datapath: window memories, sum pipeline, serial multiplier and bitwise root search.
// Depends on nwc_pkg and nwc_ram.
`timescale 1ns / 1ps

module nwc_dp #(
  parameter int MAX_SEARCH_X = nwc_pkg::MAX_SEARCH_X_DEF,
  parameter int MAX_SEARCH_Y = nwc_pkg::MAX_SEARCH_Y_DEF,
  parameter int SAMPLE_BITS  = nwc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [$clog2(MAX_SEARCH_X+1)-1:0]   hx,
  input  logic [$clog2(MAX_SEARCH_Y+1)-1:0]   hy,
  input  logic [nwc_pkg::POS_W-1:0]           in_row,
  input  logic [nwc_pkg::POS_W-1:0]           in_column,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic signed [nwc_pkg::SHIFT_W-1:0]  in_shift_x,
  input  logic signed [nwc_pkg::SHIFT_W-1:0]  in_shift_y,
  input  nwc_pkg::nwc_cmd_t                   cmd,
  output nwc_pkg::nwc_sts_t                   sts,
  output logic [nwc_pkg::CORR_W-1:0]          correlation,
  output logic                                zero_denominator
);
  import nwc_pkg::*;

  localparam int WIN_W = 4 * MAX_SEARCH_X;
  localparam int WIN_H = 4 * MAX_SEARCH_Y;
  localparam int DEPTH = WIN_W * WIN_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW_X  = $clog2(MAX_SEARCH_X + 1);
  localparam int HW_Y  = $clog2(MAX_SEARCH_Y + 1);
  localparam int IW_X  = $clog2(2 * MAX_SEARCH_X);
  localparam int IW_Y  = $clog2(2 * MAX_SEARCH_Y);
  localparam int CW    = $clog2(WIN_W + WIN_H + (1 << POS_W)) + 2;
  localparam int FW    = AW + CW;
  localparam int MC_W  = $clog2(MY_W + 1);

  // ---- window writes
  logic              wr_ok;
  logic [FW-1:0]     wa_full;
  logic [AW-1:0]     waddr;

  assign wr_ok   = (CW'(in_row) < CW'({hy, 2'b00})) && (CW'(in_column) < CW'({hx, 2'b00}));
  assign wa_full = FW'(in_row) * FW'(WIN_W) + FW'(in_column);
  assign waddr   = wa_full[AW-1:0];

  // ---- sum walk
  logic                 issuing, v1, v2;
  logic [IW_Y-1:0]      ci;
  logic [IW_X-1:0]      cj;
  logic signed [CW-1:0] sx, sy, sx_in, sy_in, hx_s, hy_s;
  logic signed [CW-1:0] ra, ca, rb, cb;
  logic [FW-1:0]        ra_full, rb_full;
  logic [AW-1:0]        raddr_a, raddr_b;
  logic                 last_j, last_i;
  logic [SAMPLE_BITS-1:0] a_q, b_q;
  logic signed [2*SAMPLE_BITS-1:0] pab, paa, pbb;
  logic [ACC_W-1:0]     ab, aa, bb, mag;

  assign hx_s  = $signed(CW'(hx));
  assign hy_s  = $signed(CW'(hy));
  assign sx_in = CW'(in_shift_x);
  assign sy_in = CW'(in_shift_y);

  assign ra = hy_s + $signed(CW'(ci)) + sy;
  assign ca = hx_s + $signed(CW'(cj)) + sx;
  assign rb = hy_s + $signed(CW'(ci));
  assign cb = hx_s + $signed(CW'(cj));

  assign ra_full = FW'($unsigned(ra)) * FW'(WIN_W) + FW'($unsigned(ca));
  assign rb_full = FW'($unsigned(rb)) * FW'(WIN_W) + FW'($unsigned(cb));
  assign raddr_a = ra_full[AW-1:0];
  assign raddr_b = rb_full[AW-1:0];

  assign last_j = (HW_X + 1)'(cj) == ({hx, 1'b0} - (HW_X + 1)'(1));
  assign last_i = (HW_Y + 1)'(ci) == ({hy, 1'b0} - (HW_Y + 1)'(1));

  nwc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram_first (
    .clk   (clk),
    .we    (cmd.wr_first && wr_ok),
    .waddr (waddr),
    .wdata (in_sample),
    .raddr (raddr_a),
    .rdata (a_q)
  );

  nwc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram_second (
    .clk   (clk),
    .we    (cmd.wr_second && wr_ok),
    .waddr (waddr),
    .wdata (in_sample),
    .raddr (raddr_b),
    .rdata (b_q)
  );

  assign mag = ab[ACC_W-1] ? (ACC_W'(0) - ab) : ab;

  // ---- serial multiplier and root search
  logic [PROD_W-1:0] mx, macc, macc_next, rsq;
  logic [MY_W-1:0]   my, ssq;
  logic [MC_W-1:0]   mcnt;
  mop_t              mop_l;
  logic [SQ_W-1:0]   psq, msq;
  logic [RBITS-1:0]  r, cand;
  logic [3:0]        k;
  logic              bits_done;
  logic              mul_end;

  assign macc_next = macc + (my[0] ? mx : '0);
  assign cand      = r | (RBITS'(1) << k);
  assign mul_end   = (mcnt == MC_W'(1));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      mcnt      <= '0;
      bits_done <= 1'b0;
      ci        <= '0;
      cj        <= '0;
      k         <= RBIT_TOP;
      r         <= '0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
      if (cmd.sum_start) begin
        issuing   <= 1'b1;
        ci        <= '0;
        cj        <= '0;
        k         <= RBIT_TOP;
        r         <= '0;
        bits_done <= 1'b0;
      end else if (issuing) begin
        if (last_j) begin
          cj <= '0;
          if (last_i) begin
            issuing <= 1'b0;
          end else begin
            ci <= ci + IW_Y'(1);
          end
        end else begin
          cj <= cj + IW_X'(1);
        end
      end
      if (cmd.mul_start) begin
        mcnt <= MC_W'(MY_W);
      end else if (mcnt != '0) begin
        mcnt <= mcnt - MC_W'(1);
        if (mul_end && (mop_l == MOP_T)) begin
          if (macc_next <= rsq) begin
            r <= cand;
          end
          if (k == 4'd0) begin
            bits_done <= 1'b1;
          end else begin
            k <= k - 4'd1;
          end
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.sum_start) begin
      sx <= (sx_in < -hx_s) ? -hx_s : ((sx_in > hx_s) ? hx_s : sx_in);
      sy <= (sy_in < -hy_s) ? -hy_s : ((sy_in > hy_s) ? hy_s : sy_in);
      ab <= '0;
      aa <= '0;
      bb <= '0;
    end else if (v2) begin
      ab <= ab + ACC_W'(pab);
      aa <= aa + ACC_W'(paa);
      bb <= bb + ACC_W'(pbb);
    end
    if (v1) begin
      pab <= $signed(a_q) * $signed(b_q);
      paa <= $signed(a_q) * $signed(a_q);
      pbb <= $signed(b_q) * $signed(b_q);
    end
    if (cmd.mul_start) begin
      macc  <= '0;
      mop_l <= cmd.mop;
      case (cmd.mop)
        MOP_P: begin
          mx <= PROD_W'(aa);
          my <= bb;
        end
        MOP_M: begin
          mx <= PROD_W'(mag);
          my <= mag;
        end
        MOP_R: begin
          mx <= PROD_W'(msq);
          my <= FULL_SCALE_SQ;
        end
        MOP_S: begin
          mx <= PROD_W'(cand);
          my <= MY_W'(cand);
        end
        MOP_T: begin
          mx <= PROD_W'(psq);
          my <= ssq;
        end
        default: begin
          mx <= '0;
          my <= '0;
        end
      endcase
    end else if (mcnt != '0) begin
      macc <= macc_next;
      mx   <= mx << 1;
      my   <= my >> 1;
      if (mul_end) begin
        case (mop_l)
          MOP_P:   psq <= macc_next[SQ_W-1:0];
          MOP_M:   msq <= macc_next[SQ_W-1:0];
          MOP_R:   rsq <= macc_next;
          MOP_S:   ssq <= macc_next[MY_W-1:0];
          default: ;
        endcase
      end
    end
    if (cmd.res_load) begin
      correlation      <= cmd.res_zero ? '0 : ((r > FULL_SCALE) ? FULL_SCALE : r);
      zero_denominator <= cmd.res_zero;
    end
  end

  assign sts.sum_busy = issuing || v1 || v2;
  assign sts.mul_busy = (mcnt != '0);
  assign sts.zero_den = (aa == '0) || (bb == '0);
  assign sts.last_bit = bits_done;

endmodule

// ----- design/normalized_window_correlation_core.sv -----
// Normalized window correlation core. Write items are taken one per cycle while the sequencer is idle.
// A compute item walks the core (one sample pair per cycle through the two window RAM
// read ports), then, unless a window energy is zero, takes 33 passes of a serial
// shift-add multiplier for the energy products and a 15-bit root search.
// Synchronous active-high reset clears the sequencer, result valid and the search
// sizes (16 each); window contents are undefined until written.
`timescale 1ns / 1ps

module normalized_window_correlation_core #(
  parameter int MAX_SEARCH_X = nwc_pkg::MAX_SEARCH_X_DEF,
  parameter int MAX_SEARCH_Y = nwc_pkg::MAX_SEARCH_Y_DEF,
  parameter int SAMPLE_BITS  = nwc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nwc_pkg::PADDR_W-1:0]   paddr,
  input  logic [nwc_pkg::PDATA_W-1:0]   pwdata,
  output logic [nwc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  nwc_in_if.sink                        in_ch,
  nwc_out_if.source                     out_ch
);
  import nwc_pkg::*;

  localparam int HW_X = $clog2(MAX_SEARCH_X + 1);
  localparam int HW_Y = $clog2(MAX_SEARCH_Y + 1);

  logic [CFG_W-1:0] search_half_x, search_half_y;
  logic [HW_X-1:0]  hx;
  logic [HW_Y-1:0]  hy;
  nwc_cmd_t         cmd;
  nwc_sts_t         sts;

  // APB registers: index in paddr[2], zero wait states
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_half_x <= CFG_RESET;
      search_half_y <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SEARCH_X: search_half_x <= pwdata[CFG_W-1:0];
        REG_SEARCH_Y: search_half_y <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SEARCH_X: prdata = PDATA_W'(search_half_x);
      REG_SEARCH_Y: prdata = PDATA_W'(search_half_y);
      default:      prdata = '0;
    endcase
  end

  // effective search sizes: zero acts as one, saturate at the build maximum
  always_comb begin
    if (search_half_x == '0) begin
      hx = HW_X'(1);
    end else if (int'(search_half_x) > MAX_SEARCH_X) begin
      hx = HW_X'(MAX_SEARCH_X);
    end else begin
      hx = HW_X'(search_half_x);
    end
    if (search_half_y == '0) begin
      hy = HW_Y'(1);
    end else if (int'(search_half_y) > MAX_SEARCH_Y) begin
      hy = HW_Y'(MAX_SEARCH_Y);
    end else begin
      hy = HW_Y'(search_half_y);
    end
  end

  // sequencer: owns both handshakes; writes pass straight to the RAMs
  nwc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // datapath: windows, sums, multiplier, root search, result register
  nwc_dp #(
    .MAX_SEARCH_X (MAX_SEARCH_X),
    .MAX_SEARCH_Y (MAX_SEARCH_Y),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .hx               (hx),
    .hy               (hy),
    .in_row           (in_ch.row),
    .in_column        (in_ch.column),
    .in_sample        (in_ch.sample),
    .in_shift_x       (in_ch.shift_x),
    .in_shift_y       (in_ch.shift_y),
    .cmd              (cmd),
    .sts              (sts),
    .correlation      (out_ch.correlation),
    .zero_denominator (out_ch.zero_denominator)
  );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for normalized_window_correlation_core: window loads, compute items,
// search-size registers over APB, random idling on both item channels.
// Depends on nwc_pkg, nwc_if and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import nwc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;   // ignored by the core
  localparam int WIN = 128;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [15:0]        smp;
    logic [SHIFT_W-1:0] sx;
    logic [SHIFT_W-1:0] sy;
    bit                 typed;   // expectation given in the table
    logic [CORR_W-1:0]  corr;
    bit                 zd;
  } stim_t;

  typedef struct {
    logic [CORR_W-1:0] corr;
    bit                zd;
  } corr_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  nwc_in_if  in_ch ();
  nwc_out_if out_ch ();

  normalized_window_correlation_core uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: window copies and search-size registers
  logic signed [15:0] win_a [WIN][WIN];
  logic signed [15:0] win_b [WIN][WIN];
  logic [CFG_W-1:0] size_x_reg = CFG_RESET;
  logic [CFG_W-1:0] size_y_reg = CFG_RESET;

  corr_res_t corr_q[$];
  int fails = 0;
  int cycles = 0;
  int send_idle = 0;     // percent of cycles the sender holds off
  int recv_stall = 0;    // percent of cycles the receiver holds off
  int hold_cycles = 0;   // long receiver hold-off, counted down below

  function automatic int eff_size(logic [CFG_W-1:0] r);
    if (r < 1) return 1;
    if (r > 32) return 32;
    return int'(r);
  endfunction

  function automatic int clamp_shift(logic [SHIFT_W-1:0] s, int lim);
    int v;
    v = int'($signed(s));
    if (v < -lim) return -lim;
    if (v > lim) return lim;
    return v;
  endfunction

  // exact floor(25600*|ab|/sqrt(aa*bb)) by bisection on wide integers
  function automatic corr_res_t correlate(logic [SHIFT_W-1:0] sxr, logic [SHIFT_W-1:0] syr);
    corr_res_t res;
    int hx, hy, sx, sy;
    longint a, b;
    logic [63:0] ab, aa, bb, mag;
    logic [191:0] rhs, lhs;
    int unsigned lo, hi, mid;
    hx = eff_size(size_x_reg);
    hy = eff_size(size_y_reg);
    sx = clamp_shift(sxr, hx);
    sy = clamp_shift(syr, hy);
    ab = 0; aa = 0; bb = 0;
    for (int i = 0; i < 2 * hy; i++)
      for (int j = 0; j < 2 * hx; j++) begin
        a = longint'(win_a[hy + i + sy][hx + j + sx]);
        b = longint'(win_b[hy + i][hx + j]);
        ab += 64'(a * b);
        aa += 64'(a * a);
        bb += 64'(b * b);
      end
    if (aa == 0 || bb == 0) begin
      res.corr = '0;
      res.zd = 1'b1;
      return res;
    end
    mag = ab[63] ? -ab : ab;
    rhs = 192'(FULL_SCALE_SQ);
    rhs = rhs * mag;
    rhs = rhs * mag;
    lo = 0;
    hi = FULL_SCALE;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 192'(mid * mid);
      lhs = lhs * aa;
      lhs = lhs * bb;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    res.corr = lo[CORR_W-1:0];
    res.zd = 1'b0;
    return res;
  endfunction

  // apply one accepted item to the predictor, queue its result if any
  task automatic model_item(stim_t s);
    corr_res_t res;
    int hx, hy;
    hx = eff_size(size_x_reg);
    hy = eff_size(size_y_reg);
    case (s.cmd)
      CMD_WR_FIRST, CMD_WR_SECOND: begin
        if (s.row < 4 * hy && s.col < 4 * hx) begin
          if (s.cmd == CMD_WR_FIRST) win_a[s.row][s.col] = s.smp;
          else win_b[s.row][s.col] = s.smp;
        end
      end
      CMD_COMPUTE: begin
        if (s.typed) begin
          res.corr = s.corr;
          res.zd = s.zd;
        end else begin
          res = correlate(s.sx, s.sy);
        end
        corr_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  // entered and left at a falling edge
  task automatic send_item(stim_t s);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.command = s.cmd;
    in_ch.row = s.row;
    in_ch.column = s.col;
    in_ch.sample = s.smp;
    in_ch.shift_x = s.sx;
    in_ch.shift_y = s.sy;
    do @(posedge clk); while (!in_ch.ready);
    model_item(s);
    @(negedge clk);
  endtask

  function automatic stim_t mk(logic [CMD_W-1:0] c, int r, int col, int smp, int sx, int sy);
    stim_t s;
    s.cmd = c;
    s.row = POS_W'(r);
    s.col = POS_W'(col);
    s.smp = 16'(smp);
    s.sx = SHIFT_W'(sx);
    s.sy = SHIFT_W'(sy);
    s.typed = 1'b0;
    s.corr = '0;
    s.zd = 1'b0;
    return s;
  endfunction

  function automatic stim_t mk_exp(int sx, int sy, int corr, bit zd);
    stim_t s;
    s = mk(CMD_COMPUTE, 0, 0, 0, sx, sy);
    s.typed = 1'b1;
    s.corr = CORR_W'(corr);
    s.zd = zd;
    return s;
  endfunction

  // registers are written only with the input channel idle
  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = PDATA_W'(val);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_SEARCH_X) size_x_reg = val;
    else size_y_reg = val;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // let every expected result drain, then a short guard for trailing writes
  task automatic drain();
    in_ch.valid = 1'b0;
    while (corr_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // load both windows over the whole effective area so no compute reads a hole
  task automatic fill_windows(bit zeros);
    int hx, hy;
    hx = eff_size(size_x_reg);
    hy = eff_size(size_y_reg);
    for (int w = 0; w < 2; w++)
      for (int r = 0; r < 4 * hy; r++)
        for (int c = 0; c < 4 * hx; c++)
          send_item(mk(w == 0 ? CMD_WR_FIRST : CMD_WR_SECOND, r, c,
                       zeros ? 0 : int'($urandom_range(65535)), 0, 0));
  endtask

  function automatic stim_t rand_item();
    int hx, hy, pick;
    stim_t s;
    hx = eff_size(size_x_reg);
    hy = eff_size(size_y_reg);
    pick = $urandom_range(99);
    s = mk(CMD_WR_FIRST, 0, 0, 0, 0, 0);
    s.smp = 16'($urandom_range(65535));
    s.sx = SHIFT_W'($urandom_range(127));
    s.sy = SHIFT_W'($urandom_range(127));
    if (pick < 10) begin
      s.cmd = CMD_COMPUTE;
    end else if (pick < 13) begin
      s.cmd = CMD_RESERVED;
      s.row = POS_W'($urandom_range(127));
      s.col = POS_W'($urandom_range(127));
    end else begin
      s.cmd = $urandom_range(1) ? CMD_WR_SECOND : CMD_WR_FIRST;
      if (pick < 20) begin
        // anywhere, mostly outside the window
        s.row = POS_W'($urandom_range(127));
        s.col = POS_W'($urandom_range(127));
      end else begin
        s.row = POS_W'($urandom_range(4 * hy - 1));
        s.col = POS_W'($urandom_range(4 * hx - 1));
      end
    end
    return s;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $time);
    fails++;
  endtask

  // receiver: random stalls, or a long hold-off while hold_cycles runs down
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall);
    end
  end

  // result checker
  always @(posedge clk) begin
    corr_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (corr_q.size() == 0) begin
        report("unexpected result", int'(out_ch.correlation), -1);
      end else begin
        want = corr_q.pop_front();
        if (out_ch.correlation !== want.corr)
          report("correlation", int'(out_ch.correlation), int'(want.corr));
        if (out_ch.zero_denominator !== want.zd)
          report("zero_denominator", int'(out_ch.zero_denominator), int'(want.zd));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  stim_t directed[$];
  // small cores keep the window loads short; zero acts as one
  int cfg_x[6] = '{2, 1, 0, 2, 1, 2};
  int cfg_y[6] = '{1, 2, 1, 0, 1, 2};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_WR_FIRST;
    in_ch.row = '0;
    in_ch.column = '0;
    in_ch.sample = '0;
    in_ch.shift_x = '0;
    in_ch.shift_y = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // smallest windows, all zero: core is rows/cols 1..2
    write_reg(REG_SEARCH_X, 6'd1);
    write_reg(REG_SEARCH_Y, 6'd1);
    fill_windows(1'b1);

    directed.push_back(mk_exp(0, 0, 0, 1'b1));          // zero energy
    directed.push_back(mk_exp(-64, -64, 0, 1'b1));      // most negative shift, clamped
    directed.push_back(mk_exp(63, 63, 0, 1'b1));        // most positive shift, clamped
    directed.push_back(mk(CMD_WR_FIRST, 127, 127, 32767, 0, 0));   // outside, ignored
    directed.push_back(mk(CMD_WR_SECOND, 4, 0, -32768, 0, 0));     // just outside
    directed.push_back(mk(CMD_RESERVED, 1, 1, 32767, 0, 0));       // ignored command
    directed.push_back(mk_exp(0, 0, 0, 1'b1));
    for (int r = 1; r <= 2; r++)
      for (int c = 1; c <= 2; c++) begin
        directed.push_back(mk(CMD_WR_FIRST, r, c, -32768, 0, 0));
        directed.push_back(mk(CMD_WR_SECOND, r, c, -32768, 0, 0));
      end
    directed.push_back(mk_exp(0, 0, 25600, 1'b0));      // identical windows: full scale
    directed.push_back(mk(CMD_WR_SECOND, 1, 1, 32767, 0, 0));
    directed.push_back(mk(CMD_WR_FIRST, 0, 3, 1, 0, 0));
    directed.push_back(mk(CMD_COMPUTE, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_COMPUTE, 0, 0, 0, 1, -1));
    directed.push_back(mk(CMD_COMPUTE, 0, 0, 0, -1, 1));
    foreach (directed[i]) send_item(directed[i]);

    // receiver holds off for a long stretch while computes keep coming,
    // so the core fills up and stalls the input
    hold_cycles = 12000;
    for (int k = 0; k < 6; k++) send_item(mk(CMD_COMPUTE, 0, 0, 0, k - 3, 2 - k));
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_SEARCH_X, CFG_W'(cfg_x[p]));
      write_reg(REG_SEARCH_Y, CFG_W'(cfg_y[p]));
      send_idle = 0;
      recv_stall = 0;
      fill_windows(1'b0);
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 66; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 66; end
        default: begin send_idle = 15; recv_stall = 15; end
      endcase
      for (int k = 0; k < 36; k++) send_item(rand_item());
      drain();
    end

    repeat (200) @(negedge clk);
    if (fails == 0 && corr_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- normalized_window_correlation_core.f -----
design/nwc_pkg.sv
design/nwc_if.sv
design/nwc_ram.sv
design/nwc_ctrl.sv
design/nwc_dp.sv
design/normalized_window_correlation_core.sv
bench/tb_top.sv
